// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by gpm_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequence checked in the same cycle
`define GPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the next cycle
`define GPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/gpm_pkg.sv -----
// ----------------------------------------------------------------------------
// gpm_pkg
// types, codes and constants of the glob pattern matcher
// ----------------------------------------------------------------------------
package gpm_pkg;

    localparam int DEF_MAX_PATTERN_CHARS = 64;
    localparam int DEF_MAX_TOKENS        = 32;

    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [1:0] {
        CMD_PAT = 2'd0,
        CMD_SUB = 2'd1,
        CMD_END = 2'd2,
        CMD_CLR = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic       raw;
    } t_in_item;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_out_item;

    typedef struct packed {
        logic       raw;
        logic [7:0] ch;
    } t_pchar;

    typedef enum logic [1:0] {
        KIND_LITERAL = 2'd0,
        KIND_ANY     = 2'd1,
        KIND_STAR    = 2'd2,
        KIND_CLASS   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        WIN_HOLD,
        WIN_SHIFT,
        WIN_LOAD
    } t_win_op;

    typedef enum logic [1:0] {
        TGT_ZERO,
        TGT_I1,
        TGT_E1
    } t_win_tgt;

    typedef enum logic {
        PASS_CLOSE,
        PASS_STEP
    } t_pass_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV,
        S_CP_TOP,
        S_SC_TILDE,
        S_SC_RBR,
        S_SC_LOOP,
        S_BD_START,
        S_BD_TILDE,
        S_BD_RBR,
        S_BD_LOOP,
        S_BD_WORD,
        S_PASS,
        S_DISPATCH,
        S_END
    } t_state;

    typedef struct packed {
        logic       in_take;
        logic       pat_write;
        logic       pat_clear;
        logic       act_init;
        logic       set_ovf;
        logic       tok_clear;
        t_win_op    win_op;
        t_win_tgt   win_tgt;
        logic       save_i;
        logic       save_e;
        logic       tok_emit;
        t_kind      tok_kind;
        logic       tok_lit_brk;
        logic       word_first;
        logic       word_clear;
        logic       word_next;
        logic       word_set_neg;
        logic       word_member;
        logic       word_range;
        logic       word_write;
        logic       pass_start;
        t_pass_mode pass_mode;
        logic       pass_run;
        logic       res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic k_valid;
        logic is_qmark;
        logic is_star;
        logic is_lbrack;
        logic is_tilde;
        logic is_rbrack;
        logic scan_range;
        logic build_more;
        logic build_range;
        logic tok_full;
        logic ovf;
        logic pass_done;
        logic out_free;
        logic word_last;
    } t_dp_stat;

endpackage

// ----- rtl/core/gpm_ram.sv -----
// ----------------------------------------------------------------------------
// gpm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module gpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/gpm_datapath.sv -----
// ----------------------------------------------------------------------------
// gpm_datapath
// pattern store, parse window, token stores, class word builder and nfa vector
// ----------------------------------------------------------------------------
module gpm_datapath import gpm_pkg::*; #(
    parameter int MAX_PATTERN_CHARS = DEF_MAX_PATTERN_CHARS,
    parameter int MAX_TOKENS        = DEF_MAX_TOKENS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in_item,
    output t_dp_stat  o_stat,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int LEN_W   = $clog2(MAX_PATTERN_CHARS + 1);
    localparam int PADDR_W = $clog2(MAX_PATTERN_CHARS);
    localparam int POS_W   = LEN_W + 1;
    localparam int TCNT_W  = $clog2(MAX_TOKENS + 1);
    localparam int TIDX_W  = $clog2(MAX_TOKENS);
    localparam int CADDR_W = TIDX_W + 2;
    localparam int ACT_W   = MAX_TOKENS + 1;

    function automatic logic raw_is(input t_pchar p, input logic v, input logic [7:0] c);
        return v && p.raw && (p.ch == c);
    endfunction

    logic [LEN_W-1:0]  r_len;
    logic [TCNT_W-1:0] r_count;
    logic              r_ovf;
    logic [ACT_W-1:0]  r_act;
    logic [POS_W-1:0]  r_k, n_k, n_k2, k1, k2, len_ext;
    logic [POS_W-1:0]  r_i, r_e;
    t_pchar            r_w0, r_w1, w2;
    logic              v0, v1, v2;
    logic [7:0]        r_ch;
    logic [63:0]       r_acc, rng_mask, mem_mask;
    logic              r_neg;
    logic [1:0]        r_wsel;
    logic [TCNT_W-1:0] r_q, n_q;
    t_pass_mode        r_mode;
    logic              r_carry, carry_n, cur;
    logic              r_ovalid;
    t_out_item         r_out;
    logic              len_full;

    logic [8:0]        pat_rdata;
    logic [9:0]        tok_rdata;
    logic [9:0]        tok_wdata;
    logic [63:0]       cls_rdata;
    t_kind             tk_kind;
    logic              running, star, accept, act_q;
    logic [7:0]        lit_val;

    assign len_ext  = POS_W'(r_len);
    assign len_full = (r_len == LEN_W'(MAX_PATTERN_CHARS));
    assign k1       = r_k + POS_W'(1);
    assign k2       = r_k + POS_W'(2);
    assign v0       = r_k < len_ext;
    assign v1       = k1 < len_ext;
    assign v2       = k2 < len_ext;
    assign w2       = t_pchar'(pat_rdata);

    // read address follows the next window position so w2 is always store[k+2]
    always_comb begin
        case (i_cmd.win_op)
            WIN_SHIFT: n_k = r_k + POS_W'(1);
            WIN_LOAD: begin
                case (i_cmd.win_tgt)
                    TGT_I1:  n_k = r_i - POS_W'(1);
                    TGT_E1:  n_k = r_e - POS_W'(1);
                    default: n_k = POS_W'(0) - POS_W'(2);
                endcase
            end
            default:   n_k = r_k;
        endcase
    end
    assign n_k2 = n_k + POS_W'(2);

    gpm_ram #(.WIDTH(9), .DEPTH(MAX_PATTERN_CHARS)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pat_write && !len_full),
        .i_waddr (r_len[PADDR_W-1:0]),
        .i_wdata ({i_in_item.raw, i_in_item.ch}),
        .i_raddr (n_k2[PADDR_W-1:0]),
        .o_rdata (pat_rdata)
    );

    assign lit_val   = i_cmd.tok_lit_brk ? CH_LBRACK : r_w0.ch;
    assign tok_wdata = {i_cmd.tok_kind, (i_cmd.tok_kind == KIND_LITERAL) ? lit_val : 8'd0};

    always_comb begin
        case (i_cmd.pass_start)
            1'b1:    n_q = '0;
            default: n_q = i_cmd.pass_run ? r_q + TCNT_W'(1) : r_q;
        endcase
    end

    gpm_ram #(.WIDTH(10), .DEPTH(MAX_TOKENS)) u_tok_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tok_emit),
        .i_waddr (r_count[TIDX_W-1:0]),
        .i_wdata (tok_wdata),
        .i_raddr (n_q[TIDX_W-1:0]),
        .o_rdata (tok_rdata)
    );

    gpm_ram #(.WIDTH(64), .DEPTH(MAX_TOKENS * 4)) u_cls_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.word_write),
        .i_waddr (CADDR_W'({r_count[TIDX_W-1:0], r_wsel})),
        .i_wdata (r_neg ? ~r_acc : r_acc),
        .i_raddr (CADDR_W'({n_q[TIDX_W-1:0], r_ch[7:6]})),
        .o_rdata (cls_rdata)
    );

    // class word masks for the 64 bytes selected by r_wsel
    always_comb begin
        logic [7:0] val;
        for (int b = 0; b < 64; b++) begin
            val         = {r_wsel, 6'(b)};
            rng_mask[b] = (r_w0.ch <= val) && (val <= w2.ch);
        end
        mem_mask = (r_w0.ch[7:6] == r_wsel) ? (64'd1 << r_w0.ch[5:0]) : 64'd0;
    end

    // one token of the nfa vector per cycle, closure carried in r_carry
    assign tk_kind = t_kind'(tok_rdata[9:8]);
    assign running = (r_q != r_count);
    assign act_q   = r_act[r_q];
    assign star    = running && (tk_kind == KIND_STAR);

    always_comb begin
        case (tk_kind)
            KIND_LITERAL: accept = (tok_rdata[7:0] == r_ch);
            KIND_ANY:     accept = 1'b1;
            KIND_CLASS:   accept = cls_rdata[r_ch[5:0]];
            default:      accept = 1'b0;
        endcase
        if (r_mode == PASS_CLOSE) begin
            cur     = r_carry | act_q;
            carry_n = star & cur;
        end else begin
            cur     = r_carry | (star & act_q);
            carry_n = star ? cur : (act_q & accept & running);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_act    <= ACT_W'(1);
            r_ovalid <= 1'b0;
            r_q      <= '0;
        end else begin
            if (i_cmd.pat_write) begin
                if (len_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_len <= r_len + LEN_W'(1);
                end
            end
            if (i_cmd.pat_clear) begin
                r_len   <= '0;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.tok_clear) begin
                r_count <= '0;
            end
            if (i_cmd.tok_emit) begin
                r_count <= r_count + TCNT_W'(1);
            end
            if (i_cmd.act_init) begin
                r_act <= ACT_W'(1);
            end
            r_q <= n_q;
            if (i_cmd.pass_run) begin
                r_act[r_q] <= cur;
            end
            if (i_cmd.res_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (i_cmd.win_op == WIN_SHIFT) begin
            r_w0 <= r_w1;
            r_w1 <= w2;
        end
        if (i_cmd.save_i) begin
            r_i <= r_k;
        end
        if (i_cmd.save_e) begin
            r_e <= r_k;
        end
        if (i_cmd.in_take) begin
            r_ch <= i_in_item.ch;
        end
        if (i_cmd.word_first) begin
            r_wsel <= 2'd0;
        end else if (i_cmd.word_next) begin
            r_wsel <= r_wsel + 2'd1;
        end
        if (i_cmd.word_clear) begin
            r_acc <= '0;
            r_neg <= 1'b0;
        end else begin
            if (i_cmd.word_set_neg) begin
                r_neg <= 1'b1;
            end
            if (i_cmd.word_member) begin
                r_acc <= r_acc | mem_mask;
            end else if (i_cmd.word_range) begin
                r_acc <= r_acc | rng_mask;
            end
        end
        if (i_cmd.pass_start) begin
            r_carry <= 1'b0;
            r_mode  <= i_cmd.pass_mode;
        end else if (i_cmd.pass_run) begin
            r_carry <= carry_n;
        end
        if (i_cmd.res_load) begin
            r_out.matched  <= !r_ovf && r_act[r_count];
            r_out.overflow <= r_ovf;
        end
    end

    always_comb begin
        o_stat.k_valid     = v0;
        o_stat.is_qmark    = raw_is(r_w0, v0, CH_QMARK);
        o_stat.is_star     = raw_is(r_w0, v0, CH_STAR);
        o_stat.is_lbrack   = raw_is(r_w0, v0, CH_LBRACK);
        o_stat.is_tilde    = raw_is(r_w0, v0, CH_TILDE);
        o_stat.is_rbrack   = raw_is(r_w0, v0, CH_RBRACK);
        o_stat.scan_range  = raw_is(r_w1, v1, CH_DASH) && v2 && !raw_is(w2, v2, CH_RBRACK);
        o_stat.build_more  = r_k < r_e;
        o_stat.build_range = (k2 < r_e) && raw_is(r_w1, v1, CH_DASH)
                             && !raw_is(w2, v2, CH_RBRACK);
        o_stat.tok_full    = (r_count == TCNT_W'(MAX_TOKENS));
        o_stat.ovf         = r_ovf;
        o_stat.pass_done   = !running;
        o_stat.out_free    = !r_ovalid || i_out_ready;
        o_stat.word_last   = (r_wsel == 2'd3);
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/core/gpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// gpm_ctrl
// sequencer for pattern compile, class building, nfa passes and results
// ----------------------------------------------------------------------------
module gpm_ctrl import gpm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_cmd     i_cmd,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    t_state     r_state, n_state;
    t_state     r_ret, n_ret;
    t_state     r_pret, n_pret;
    logic [1:0] r_adv, n_adv;
    logic       r_compiled, n_compiled;
    t_cmd       r_pcmd, n_pcmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_pret     <= S_IDLE;
            r_adv      <= 2'd0;
            r_compiled <= 1'b0;
            r_pcmd     <= CMD_PAT;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_pret     <= n_pret;
            r_adv      <= n_adv;
            r_compiled <= n_compiled;
            r_pcmd     <= n_pcmd;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_pret     = r_pret;
        n_adv      = r_adv;
        n_compiled = r_compiled;
        n_pcmd     = r_pcmd;
        o_cmd      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_cmd)
                        CMD_PAT: begin
                            o_cmd.pat_write = 1'b1;
                            o_cmd.act_init  = 1'b1;
                            n_compiled      = 1'b0;
                        end
                        CMD_CLR: begin
                            o_cmd.pat_clear = 1'b1;
                            o_cmd.act_init  = 1'b1;
                            n_compiled      = 1'b0;
                        end
                        default: begin
                            o_cmd.in_take = 1'b1;
                            n_pcmd        = i_cmd;
                            if (!r_compiled) begin
                                o_cmd.tok_clear = 1'b1;
                                o_cmd.win_op    = WIN_LOAD;
                                o_cmd.win_tgt   = TGT_ZERO;
                                n_adv           = 2'd2;
                                n_ret           = S_CP_TOP;
                                n_state         = S_ADV;
                            end else begin
                                n_state = S_DISPATCH;
                            end
                        end
                    endcase
                end
            end
            S_ADV: begin
                o_cmd.win_op = WIN_SHIFT;
                n_adv        = r_adv - 2'd1;
                if (r_adv == 2'd1) begin
                    n_state = r_ret;
                end
            end
            S_CP_TOP: begin
                if (!i_stat.k_valid || i_stat.tok_full) begin
                    o_cmd.set_ovf    = i_stat.k_valid;
                    n_compiled       = 1'b1;
                    o_cmd.act_init   = 1'b1;
                    o_cmd.pass_start = 1'b1;
                    o_cmd.pass_mode  = PASS_CLOSE;
                    n_pret           = S_DISPATCH;
                    n_state          = S_PASS;
                end else if (i_stat.is_lbrack) begin
                    o_cmd.save_i = 1'b1;
                    o_cmd.win_op = WIN_SHIFT;
                    n_state      = S_SC_TILDE;
                end else begin
                    o_cmd.tok_emit = 1'b1;
                    o_cmd.win_op   = WIN_SHIFT;
                    if (i_stat.is_qmark) begin
                        o_cmd.tok_kind = KIND_ANY;
                    end else if (i_stat.is_star) begin
                        o_cmd.tok_kind = KIND_STAR;
                    end else begin
                        o_cmd.tok_kind = KIND_LITERAL;
                    end
                end
            end
            S_SC_TILDE: begin
                if (i_stat.is_tilde) begin
                    o_cmd.win_op = WIN_SHIFT;
                end
                n_state = S_SC_RBR;
            end
            S_SC_RBR: begin
                if (i_stat.is_rbrack) begin
                    o_cmd.win_op = WIN_SHIFT;
                end
                n_state = S_SC_LOOP;
            end
            S_SC_LOOP: begin
                if (!i_stat.k_valid) begin
                    // no closing bracket: the bracket is a literal
                    o_cmd.tok_emit    = 1'b1;
                    o_cmd.tok_kind    = KIND_LITERAL;
                    o_cmd.tok_lit_brk = 1'b1;
                    o_cmd.win_op      = WIN_LOAD;
                    o_cmd.win_tgt     = TGT_I1;
                    n_adv             = 2'd2;
                    n_ret             = S_CP_TOP;
                    n_state           = S_ADV;
                end else if (i_stat.is_rbrack) begin
                    o_cmd.save_e     = 1'b1;
                    o_cmd.word_first = 1'b1;
                    n_state          = S_BD_START;
                end else if (i_stat.scan_range) begin
                    o_cmd.win_op = WIN_SHIFT;
                    n_adv        = 2'd2;
                    n_ret        = S_SC_LOOP;
                    n_state      = S_ADV;
                end else begin
                    o_cmd.win_op = WIN_SHIFT;
                end
            end
            S_BD_START: begin
                o_cmd.word_clear = 1'b1;
                o_cmd.win_op     = WIN_LOAD;
                o_cmd.win_tgt    = TGT_I1;
                n_adv            = 2'd2;
                n_ret            = S_BD_TILDE;
                n_state          = S_ADV;
            end
            S_BD_TILDE: begin
                if (i_stat.build_more && i_stat.is_tilde) begin
                    o_cmd.word_set_neg = 1'b1;
                    o_cmd.win_op       = WIN_SHIFT;
                end
                n_state = S_BD_RBR;
            end
            S_BD_RBR: begin
                if (i_stat.build_more && i_stat.is_rbrack) begin
                    o_cmd.word_member = 1'b1;
                    o_cmd.win_op      = WIN_SHIFT;
                end
                n_state = S_BD_LOOP;
            end
            S_BD_LOOP: begin
                if (!i_stat.build_more) begin
                    n_state = S_BD_WORD;
                end else if (i_stat.build_range) begin
                    o_cmd.word_range = 1'b1;
                    o_cmd.win_op     = WIN_SHIFT;
                    n_adv            = 2'd2;
                    n_ret            = S_BD_LOOP;
                    n_state          = S_ADV;
                end else begin
                    o_cmd.word_member = 1'b1;
                    o_cmd.win_op      = WIN_SHIFT;
                end
            end
            S_BD_WORD: begin
                o_cmd.word_write = 1'b1;
                if (i_stat.word_last) begin
                    o_cmd.tok_emit = 1'b1;
                    o_cmd.tok_kind = KIND_CLASS;
                    o_cmd.win_op   = WIN_LOAD;
                    o_cmd.win_tgt  = TGT_E1;
                    n_adv          = 2'd2;
                    n_ret          = S_CP_TOP;
                    n_state        = S_ADV;
                end else begin
                    o_cmd.word_next = 1'b1;
                    n_state         = S_BD_START;
                end
            end
            S_PASS: begin
                o_cmd.pass_run = 1'b1;
                if (i_stat.pass_done) begin
                    n_state = r_pret;
                end
            end
            S_DISPATCH: begin
                if (r_pcmd == CMD_SUB) begin
                    if (i_stat.ovf) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.pass_start = 1'b1;
                        o_cmd.pass_mode  = PASS_STEP;
                        n_pret           = S_IDLE;
                        n_state          = S_PASS;
                    end
                end else begin
                    n_state = S_END;
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.act_init   = 1'b1;
                    o_cmd.pass_start = 1'b1;
                    o_cmd.pass_mode  = PASS_CLOSE;
                    n_pret           = S_IDLE;
                    n_state          = S_PASS;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/glob_pattern_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// glob_pattern_matcher_unit
// glob pattern matcher with a compiled token nfa
// ----------------------------------------------------------------------------
// A pattern char or clear item is taken in the idle state. A subject char or an
// end item walks the nfa vector one token per cycle through the token and class
// rams, and no new item is taken until that walk is done. The first subject or
// end item after the pattern changes first compiles it: a walk over the pattern
// chars, plus for each bracket class a scan to its closing bracket and four
// sweeps over its members (one per 64-byte word of the class map). An end
// item's result waits in an output register.
module glob_pattern_matcher_unit import gpm_pkg::*; #(
    parameter int MAX_PATTERN_CHARS = DEF_MAX_PATTERN_CHARS,
    parameter int MAX_TOKENS        = DEF_MAX_TOKENS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    gpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (t_cmd'(i_in_item.cmd)),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    gpm_datapath #(
        .MAX_PATTERN_CHARS (MAX_PATTERN_CHARS),
        .MAX_TOKENS        (MAX_TOKENS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_item   (i_in_item),
        .o_stat      (dp_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- rtl/core/gpm_checker.sv -----
// ----------------------------------------------------------------------------
// gpm_checker
// port level checks of the glob pattern matcher, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpm_checker import gpm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    logic take_sub_end;
    logic take_pat_clr;

    assign take_sub_end = i_in_valid && o_in_ready
                          && (i_in_item.cmd == CMD_SUB || i_in_item.cmd == CMD_END);
    assign take_pat_clr = i_in_valid && o_in_ready
                          && (i_in_item.cmd == CMD_PAT || i_in_item.cmd == CMD_CLR);

    `GPM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result item changed while stalled")
    `GPM_ASSERT_NOW(a_ovf_no_match, o_out_valid, !(o_out_item.matched && o_out_item.overflow), "overflowed pattern reported a match")
    `GPM_ASSERT_NEXT(a_sub_busy, take_sub_end, !o_in_ready, "subject item did not occupy the block")
    `GPM_ASSERT_NEXT(a_pat_quick, take_pat_clr, o_in_ready, "pattern item took more than one cycle")
    `GPM_ASSERT_NOW(a_rise_busy, $rose(o_out_valid), !o_in_ready, "result appeared without restart pass")

endmodule

bind glob_pattern_matcher_unit gpm_checker u_gpm_checker (.*);
